// File: design/frame_averaging_accumulator_core_defines.svh
// assertion macros shared by the frame averaging checker
// expects clk and rst in scope where a macro is used
`ifndef FRAME_AVERAGING_ACCUMULATOR_CORE_DEFINES_SVH
`define FRAME_AVERAGING_ACCUMULATOR_CORE_DEFINES_SVH

// generic clocked property, disabled during reset
`define FAV_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) expr) \
    else $error(msg);

// a stalled item keeps valid high and its payload unchanged
`define FAV_ASSERT_STALL(lbl, vld, rdy, pl, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) \
    (vld && !rdy) |=> (vld && $stable(pl))) \
    else $error(msg);

`endif

// File: design/fav_pkg.sv
// shared types and constants of the frame averaging accumulator
// no dependencies
package fav_pkg;

  localparam int MODE_W = 2;
  localparam int PIX_W  = 16;
  localparam int SUM_W  = 32;
  localparam int CNT_W  = 16;
  localparam int CFG_W  = 21;

  localparam logic [CNT_W-1:0] COUNTER_MAX = 16'hFFFF;

  typedef enum logic [MODE_W-1:0] {
    MODE_ACC  = 2'd0,
    MODE_READ = 2'd1,
    MODE_RAW  = 2'd2,
    MODE_NONE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MEM,
    ST_DIV,
    ST_OUT
  } state_t;

endpackage

// File: design/fav_in_if.sv
// input item channel: mode and pixel sample
// depends on fav_pkg
interface fav_in_if;
  import fav_pkg::*;

  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [PIX_W-1:0]  pixel_value;

  modport source (output valid, output mode, output pixel_value, input ready);
  modport sink   (input valid, input mode, input pixel_value, output ready);
endinterface

// File: design/fav_out_if.sv
// result item channel: pixel, frame flag, frame count and status
// depends on fav_pkg
interface fav_out_if;
  import fav_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;
  logic             frame_done;
  logic [CNT_W-1:0] frames_summed;
  logic             status;

  modport source (output valid, output pixel_out, output frame_done,
                  output frames_summed, output status, input ready);
  modport sink   (input valid, input pixel_out, input frame_done,
                  input frames_summed, input status, output ready);
endinterface

// File: design/fav_cfg_if.sv
// configuration write channel for the pixel count register
// depends on fav_pkg
interface fav_cfg_if;
  import fav_pkg::*;

  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] pixel_count;

  modport source (output valid, output pixel_count, input ready);
  modport sink   (input valid, input pixel_count, output ready);
endinterface

// File: design/frame_averaging_accumulator_core.sv
// frame averaging accumulator top level: control, position and frame counters
// depends on fav_pkg, the channel interfaces, fav_store and fav_div
//
// Averages camera frames per pixel. Each input item carries a mode and a
// 16-bit pixel; an internal position steps through pixel_count pixels and
// wraps. Accumulate sums into a 32-bit sum memory (first frame overwrites),
// read returns sum divided by the frame count and saves it in the image memory
// (with no frame summed it returns the image entry), store raw writes the pixel
// into the image memory. Items are taken one at a time: each passes accept,
// memory read and result, and an averaged read also waits for the divider,
// which produces one quotient bit per cycle. A new item is taken while the
// previous result still waits in the output register. Both memories hold
// MAX_PIXELS entries and are not cleared at reset; image entries must be
// written before they are read. A pixel_count write clears the position and
// the frame count, 0 acts as 1 and values above MAX_PIXELS act as MAX_PIXELS.
module frame_averaging_accumulator_core #(
  parameter int MAX_PIXELS = 1048576
) (
  input  logic     clk,
  input  logic     rst,
  fav_in_if.sink   pix_in,
  fav_out_if.source result,
  fav_cfg_if.sink  cfg
);
  import fav_pkg::*;

  localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int CW = $clog2(MAX_PIXELS + 1);

  state_t state, state_next;

  logic [AW-1:0]    pos;
  logic [AW-1:0]    pos_next;
  logic [CW-1:0]    pos_inc;
  logic [CW-1:0]    cnt_eff;
  logic [CW-1:0]    cnt_cfg;
  logic [31:0]      cfg_wide;
  logic [CNT_W-1:0] frame_cnt;
  logic [CNT_W-1:0] frame_cnt_next;
  logic             last;
  logic             in_acc;
  logic             cfg_acc;
  mode_t            in_mode;

  mode_t            it_mode;
  logic [PIX_W-1:0] it_pix;
  logic [AW-1:0]    it_addr;
  logic             it_last;
  logic             it_sat;
  logic [CNT_W-1:0] it_cnt_old;

  logic [PIX_W-1:0] hold_pix;
  logic [PIX_W-1:0] hold_val;
  logic             hold_load;
  logic             res_load;
  logic             res_valid;
  logic [PIX_W-1:0] res_pixel;
  logic             res_done;
  logic [CNT_W-1:0] res_frames;
  logic             res_status;

  logic             sum_wr;
  logic [SUM_W-1:0] sum_wr_data;
  logic [SUM_W-1:0] sum_rd;
  logic             img_wr;
  logic [PIX_W-1:0] img_wr_data;
  logic [PIX_W-1:0] img_rd;
  logic             div_start;
  logic             div_done;
  logic [PIX_W-1:0] div_q;

  assign cfg.ready    = (state == ST_IDLE);
  assign pix_in.ready = (state == ST_IDLE) && !cfg.valid;
  assign cfg_acc      = cfg.valid && cfg.ready;
  assign in_acc       = pix_in.valid && pix_in.ready;
  assign in_mode      = mode_t'(pix_in.mode);

  // clamp the written count into 1..MAX_PIXELS
  assign cfg_wide = 32'(cfg.pixel_count);
  always_comb begin
    if (cfg_wide == 32'd0) begin
      cnt_cfg = CW'(1);
    end else if (cfg_wide > 32'(MAX_PIXELS)) begin
      cnt_cfg = CW'(MAX_PIXELS);
    end else begin
      cnt_cfg = CW'(cfg_wide);
    end
  end

  assign pos_inc = CW'(pos) + CW'(1);
  assign last    = pos_inc >= cnt_eff;

  always_comb begin
    pos_next       = pos;
    frame_cnt_next = frame_cnt;
    unique case (in_mode)
      MODE_ACC: begin
        pos_next = last ? '0 : pos + AW'(1);
        if (frame_cnt != COUNTER_MAX && last) begin
          frame_cnt_next = frame_cnt + CNT_W'(1);
        end
      end
      MODE_READ: begin
        pos_next = last ? '0 : pos + AW'(1);
        if (frame_cnt != '0 && last) begin
          frame_cnt_next = '0;
        end
      end
      MODE_RAW: begin
        pos_next = last ? '0 : pos + AW'(1);
      end
      MODE_NONE: begin
        pos_next = pos;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pos       <= '0;
      frame_cnt <= '0;
      cnt_eff   <= CW'(MAX_PIXELS);
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_acc) begin
        cnt_eff   <= cnt_cfg;
        pos       <= '0;
        frame_cnt <= '0;
      end else if (in_acc) begin
        pos       <= pos_next;
        frame_cnt <= frame_cnt_next;
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      it_mode    <= in_mode;
      it_pix     <= pix_in.pixel_value;
      it_addr    <= pos;
      it_last    <= last;
      it_sat     <= (in_mode == MODE_ACC) && (frame_cnt == COUNTER_MAX);
      it_cnt_old <= frame_cnt;
    end
    if (hold_load) begin
      hold_pix <= hold_val;
    end
    if (res_load) begin
      res_pixel  <= hold_pix;
      res_done   <= (it_mode != MODE_NONE) && it_last;
      res_frames <= frame_cnt;
      res_status <= it_sat;
    end
  end

  always_comb begin
    state_next = state;
    sum_wr     = 1'b0;
    img_wr     = 1'b0;
    div_start  = 1'b0;
    hold_load  = 1'b0;
    hold_val   = '0;
    res_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          state_next = ST_MEM;
        end
      end
      ST_MEM: begin
        state_next = ST_OUT;
        hold_load  = 1'b1;
        unique case (it_mode)
          MODE_ACC: begin
            sum_wr = !it_sat;
          end
          MODE_READ: begin
            if (it_cnt_old != '0) begin
              div_start  = 1'b1;
              hold_load  = 1'b0;
              state_next = ST_DIV;
            end else begin
              hold_val = img_rd;
            end
          end
          MODE_RAW: begin
            img_wr = 1'b1;
          end
          MODE_NONE: begin
            hold_val = '0;
          end
        endcase
      end
      ST_DIV: begin
        if (div_done) begin
          img_wr     = 1'b1;
          hold_load  = 1'b1;
          hold_val   = div_q;
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!res_valid || result.ready) begin
          res_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  assign sum_wr_data = (it_cnt_old == '0) ? SUM_W'(it_pix) : sum_rd + SUM_W'(it_pix);
  assign img_wr_data = (state == ST_DIV) ? div_q : it_pix;

  fav_store #(
    .DEPTH (MAX_PIXELS),
    .WIDTH (SUM_W)
  ) u_sum_store (
    .clk     (clk),
    .wr_en   (sum_wr),
    .wr_addr (it_addr),
    .wr_data (sum_wr_data),
    .rd_en   (in_acc),
    .rd_addr (pos),
    .rd_data (sum_rd)
  );

  fav_store #(
    .DEPTH (MAX_PIXELS),
    .WIDTH (PIX_W)
  ) u_image_store (
    .clk     (clk),
    .wr_en   (img_wr),
    .wr_addr (it_addr),
    .wr_data (img_wr_data),
    .rd_en   (in_acc),
    .rd_addr (pos),
    .rd_data (img_rd)
  );

  fav_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_rd),
    .divisor  (it_cnt_old),
    .done     (div_done),
    .quotient (div_q)
  );

  assign result.valid         = res_valid;
  assign result.pixel_out     = res_pixel;
  assign result.frame_done    = res_done;
  assign result.frames_summed = res_frames;
  assign result.status        = res_status;

endmodule

// File: design/fav_store.sv
// synchronous memory, one write port and one registered read port
// no dependencies
module fav_store #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: design/fav_div.sv
// iterative restoring divider, one quotient bit per cycle
// depends on fav_pkg
module fav_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [fav_pkg::SUM_W-1:0] dividend,
  input  logic [fav_pkg::CNT_W-1:0] divisor,
  output logic                      done,
  output logic [fav_pkg::PIX_W-1:0] quotient
);
  import fav_pkg::*;

  localparam int STEP_W = $clog2(SUM_W);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [SUM_W-1:0]  qd;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  dsr;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;
  logic              ge;

  assign trial = {rem, qd[SUM_W-1]};
  assign ge    = trial >= {1'b0, dsr};
  assign diff  = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + STEP_W'(1);
        if (step == STEP_W'(SUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      qd  <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      qd  <= {qd[SUM_W-2:0], ge};
      rem <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
    end
  end

  assign quotient = qd[PIX_W-1:0];

endmodule

// File: design/fav_checker.sv
// port-level checks of the frame averaging accumulator, bound to the top level
// depends on fav_pkg and frame_averaging_accumulator_core_defines.svh
`include "frame_averaging_accumulator_core_defines.svh"

module fav_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [fav_pkg::PIX_W-1:0] pixel_out,
  input logic                      frame_done,
  input logic [fav_pkg::CNT_W-1:0] frames_summed,
  input logic                      status
);
  import fav_pkg::*;

  logic [PIX_W+CNT_W+1:0] out_payload;
  logic [1:0]             inflight;
  logic                   in_acc;
  logic                   out_acc;

  assign out_payload = {pixel_out, frame_done, frames_summed, status};
  assign in_acc      = in_valid && in_ready;
  assign out_acc     = out_valid && out_ready;

  // items accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else if (in_acc && !out_acc) begin
      inflight <= inflight + 2'd1;
    end else if (!in_acc && out_acc) begin
      inflight <= inflight - 2'd1;
    end
  end

  `FAV_ASSERT_STALL(a_out_stall, out_valid, out_ready, out_payload, "result changed while stalled")

  `FAV_ASSERT(a_status_sat, (out_valid && status) |-> (frames_summed == COUNTER_MAX && pixel_out == '0), "refused accumulate without saturated count")

  `FAV_ASSERT(a_no_invented, out_valid |-> (inflight != 2'd0), "result without an accepted item")

  `FAV_ASSERT(a_inflight_max, inflight != 2'd3, "more than two items in flight")

endmodule

bind frame_averaging_accumulator_core fav_checker u_fav_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (pix_in.valid),
  .in_ready      (pix_in.ready),
  .out_valid     (result.valid),
  .out_ready     (result.ready),
  .pixel_out     (result.pixel_out),
  .frame_done    (result.frame_done),
  .frames_summed (result.frames_summed),
  .status        (result.status)
);
